FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define FFBCS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define FFBCS_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define FFBCS_ASSERT(lbl, clk, rstn, prop, msg)
`define FFBCS_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

FILE: design/ffbcs_pkg.sv
// ----------------------------------------------------------------------------
// ffbcs_pkg
// Types, constants and elaboration-time tables of the command byte shaper.
// ----------------------------------------------------------------------------
package ffbcs_pkg;

  // Fixed-point formats.
  localparam int STRENGTH_FRAC_BITS = 15;
  localparam int STATE_FRAC_BITS    = 18;
  localparam int STATE_W            = STATE_FRAC_BITS + 2;
  localparam int RESCALE_SH         = STATE_FRAC_BITS - STRENGTH_FRAC_BITS;
  localparam int DEADBAND_MAX       = ((2 ** (STATE_FRAC_BITS + 1)) - 1) / 1000;

  // Queue between decoder and datapath.
  localparam int QUEUE_DEPTH = 4;

  // Watched addresses.
  localparam logic [31:0] ADDR_RALLY   = 32'h0017_4CF4;
  localparam logic [31:0] ADDR_GEN_ABS = 32'h0057_285B;
  localparam logic [31:0] ADDR_GEN_REL = 32'h0017_285B;

  // Division by 100: multiply by floor(2^33/100), then one correction step.
  localparam logic [26:0] RECIP_100 = 27'd85899345;
  // floor(2^30/13); the remainder term is added separately.
  localparam logic [26:0] INV_13    = 27'd82595524;

  typedef enum logic [2:0] {
    K_NONE, K_SPRING, K_FRICTION, K_VIBE, K_ROLL_L, K_ROLL_R
  } kind_e;

  typedef enum logic [1:0] {D_8, D_13, D_32} div_e;

  typedef enum logic [2:0] {
    REG_ENABLE, REG_CONST_GAIN, REG_SPRING_GAIN, REG_FRICTION_GAIN,
    REG_SINE_GAIN, REG_RUMBLE_GAIN, REG_GAMMA, REG_SMOOTHING
  } reg_e;

  // One classified command as it travels through the queue.
  typedef struct packed {
    kind_e      kind;
    div_e       dsel;
    logic       neg;
    logic [5:0] an;
  } job_t;

  typedef struct packed {
    logic       enable;
    logic [7:0] constant_gain;
    logic [7:0] spring_gain;
    logic [7:0] friction_gain;
    logic [7:0] sine_gain;
    logic [7:0] rumble_gain;
    logic [7:0] gamma;
    logic [7:0] smoothing;
  } cfg_t;

  // Bitwise integer square root, evaluated at elaboration only.
  function automatic logic [63:0] isqrt_f(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    x = v;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Table of 2^(-2^-k) in Q30 for k = 1..16, built by the square root chain.
  function automatic logic [15:0][30:0] exp_rom_f();
    logic [15:0][30:0] rom;
    logic [63:0]       t;
    t = 64'd1 << 29;
    for (int k = 0; k < 16; k++) begin
      t = isqrt_f(t << 30);
      rom[k] = t[30:0];
    end
    return rom;
  endfunction

endpackage

FILE: design/ffbcs_front.sv
// ----------------------------------------------------------------------------
// ffbcs_front
// Address match and command byte decode into queue entries.
// ----------------------------------------------------------------------------
module ffbcs_front
  import ffbcs_pkg::*;
(
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] read_address_i,
  input  logic        is_relative_i,
  input  logic [7:0]  cmd_byte_i,
  input  logic        enable_i,
  input  logic        full_i,
  output logic        push_o,
  output job_t        job_o
);

  logic       rally;
  logic       generic;
  logic [8:0] offset;
  logic [8:0] n;

  // Which decoder the read address selects.
  assign rally   = is_relative_i && (read_address_i == ADDR_RALLY);
  assign generic = (!is_relative_i && (read_address_i == ADDR_GEN_ABS)) ||
                   (is_relative_i && (read_address_i == ADDR_GEN_REL));

  // Command range decode: effect kind, center offset and divisor.
  always_comb begin
    job_o.kind = K_NONE;
    job_o.dsel = D_8;
    offset     = 9'd0;
    if (rally) begin
      priority if (cmd_byte_i >= 8'hC0 && cmd_byte_i <= 8'hDF) begin
        job_o.kind = K_ROLL_L; job_o.dsel = D_32; offset = 9'd191;
      end else if (cmd_byte_i >= 8'h80 && cmd_byte_i <= 8'h9F) begin
        job_o.kind = K_ROLL_R; job_o.dsel = D_32; offset = 9'd127;
      end else begin
        job_o.kind = K_NONE;
      end
    end else begin
      priority if (cmd_byte_i >= 8'h0A && cmd_byte_i <= 8'h17) begin
        job_o.kind = K_SPRING; offset = 9'd15;
      end else if (cmd_byte_i >= 8'h20 && cmd_byte_i <= 8'h27) begin
        job_o.kind = K_FRICTION; offset = 9'd31;
      end else if (cmd_byte_i >= 8'h30 && cmd_byte_i <= 8'h3C) begin
        job_o.kind = K_SPRING; job_o.dsel = D_13; offset = 9'd47;
      end else if (cmd_byte_i >= 8'h40 && cmd_byte_i <= 8'h47) begin
        job_o.kind = K_VIBE; offset = 9'd63;
      end else if (cmd_byte_i >= 8'h50 && cmd_byte_i <= 8'h57) begin
        job_o.kind = K_ROLL_L; offset = 9'd79;
      end else if (cmd_byte_i >= 8'h60 && cmd_byte_i <= 8'h67) begin
        job_o.kind = K_ROLL_R; offset = 9'd95;
      end else begin
        job_o.kind = K_NONE;
      end
    end
    // Signed distance from the range center, split into sign and magnitude.
    job_o.neg = n[8];
    job_o.an  = n[8] ? 6'(-n) : n[5:0];
  end

  assign n = {1'b0, cmd_byte_i} - offset;

  // Reads that miss or arrive while disabled are taken and dropped.
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i && enable_i && (rally || generic);

endmodule

FILE: design/ffbcs_queue.sv
// ----------------------------------------------------------------------------
// ffbcs_queue
// Small FIFO between the decoder and the shaping datapath.
// ----------------------------------------------------------------------------
module ffbcs_queue
  import ffbcs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t head_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: design/ffbcs_back.sv
// ----------------------------------------------------------------------------
// ffbcs_back
// Curve shaping, force filter and result register around one shared multiplier.
// ----------------------------------------------------------------------------
module ffbcs_back
  import ffbcs_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       empty_i,
  input  job_t                       head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [16:0]         spring_strength_o,
  output logic [15:0]                friction_strength_o,
  output logic [15:0]                sine_strength_o,
  output logic [15:0]                rumble_low_o,
  output logic [15:0]                rumble_high_o,
  output logic                       force_direction_o,
  output logic [15:0]                force_magnitude_o
);

  localparam logic [15:0][30:0] EXP_ROM = exp_rom_f();
  localparam logic [30:0]       ONE_Q30 = 31'h4000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_XQ, S_NORM, S_LOG, S_LG, S_DMUL, S_DFIX,
    S_EXP, S_SHR, S_GMUL, S_FMUL, S_FOUT
  } state_e;

  typedef enum logic [1:0] {OP_Y, OP_GAIN, OP_FILT} op_e;

  state_e                     state_q;
  op_e                        op_q;
  job_t                       job_q;
  logic [63:0]                prod_q;
  logic [26:0]                v_q;
  logic [30:0]                m_q;
  logic [2:0]                 lz_q;
  logic [15:0]                frac_q;
  logic [3:0]                 cnt_q;
  logic [19:0]                y_q;
  logic [30:0]                r_q;
  logic                       slot_q;
  logic [15:0]                c1_q, c2_q;
  logic                       dneg_q;
  logic [20:0]                delta_q;
  logic signed [STATE_W-1:0]  filt_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  // Saturated settings.
  logic [7:0] gamma_sat, smooth_sat, gain1, gain_sel, gain_sat;
  logic       need2;

  always_comb begin
    gamma_sat  = (cfg_i.gamma < 8'd25) ? 8'd25 :
                 (cfg_i.gamma > 8'd250) ? 8'd250 : cfg_i.gamma;
    smooth_sat = (cfg_i.smoothing > 8'd100) ? 8'd100 : cfg_i.smoothing;
    unique case (job_q.kind)
      K_SPRING:   gain1 = cfg_i.spring_gain;
      K_FRICTION: gain1 = cfg_i.friction_gain;
      K_VIBE:     gain1 = cfg_i.sine_gain;
      default:    gain1 = cfg_i.constant_gain;
    endcase
    need2    = (job_q.kind == K_VIBE) || (job_q.kind == K_ROLL_L) ||
               (job_q.kind == K_ROLL_R);
    gain_sel = slot_q ? cfg_i.rumble_gain : gain1;
    gain_sat = (gain_sel > 8'd200) ? 8'd200 : gain_sel;
  end

  // Normalization of x into [1, 2) in Q30 with leading-zero count.
  logic [32:0] xq_w;
  logic [30:0] xq;
  logic [2:0]  lz;
  logic [30:0] m_norm;

  always_comb begin
    unique case (job_q.dsel)
      D_8:     xq_w = 33'(job_q.an) << 27;
      D_32:    xq_w = 33'(job_q.an) << 25;
      default: xq_w = 33'(prod_q[30:0]) + 33'(job_q.an) - 33'd1;
    endcase
    xq = (xq_w > 33'(ONE_Q30)) ? ONE_Q30 : xq_w[30:0];
    lz = 3'd5;
    for (int i = 0; i < 6; i++) begin
      if (xq[25 + i]) begin
        lz = 3'(5 - i);
      end
    end
    m_norm = xq << lz;
  end

  // Log and exp helpers.
  logic [31:0] sq;
  logic [18:0] lval;
  logic [62:0] r_step;

  assign sq     = prod[61:30];
  assign lval   = {lz_q, 16'd0} - {3'd0, frac_q};
  assign r_step = prod[62:0] + 63'(32'h2000_0000);

  // Divide-by-100 correction on the registered reciprocal product.
  logic [20:0] q0, qv;
  logic [27:0] rem;

  assign q0  = prod_q[53:33];
  assign rem = {1'b0, v_q} - (28'(q0) * 28'd100);
  assign qv  = q0 + 21'(rem >= 28'd100);

  // Filter arithmetic.
  logic signed [16:0]         target;
  logic signed [STATE_W-1:0]  tq;
  logic signed [STATE_W:0]    diff;
  logic [STATE_W-1:0]         ad;
  logic [8:0]                 factor;
  logic signed [STATE_W:0]    filt_new;
  logic [STATE_W-1:0]         abs_new;
  logic                       dead;
  logic [STATE_W-1:0]         fmag;

  always_comb begin
    unique case (job_q.kind)
      K_ROLL_L: target = -$signed({1'b0, c1_q});
      K_ROLL_R: target = $signed({1'b0, c1_q});
      default:  target = '0;
    endcase
    tq       = STATE_W'(target) <<< RESCALE_SH;
    diff     = (STATE_W + 1)'(tq) - (STATE_W + 1)'(filt_q);
    ad       = diff[STATE_W] ? STATE_W'(-diff) : STATE_W'(diff);
    factor   = 9'(10'd400 - 10'(smooth_sat) * 10'd3);
    filt_new = dneg_q ? (STATE_W + 1)'(filt_q) - $signed({1'b0, STATE_W'(delta_q)})
                      : (STATE_W + 1)'(filt_q) + $signed({1'b0, STATE_W'(delta_q)});
    abs_new  = filt_new[STATE_W] ? STATE_W'(-filt_new) : STATE_W'(filt_new);
    dead     = abs_new <= STATE_W'(DEADBAND_MAX);
    fmag     = (abs_new + STATE_W'(1 << (RESCALE_SH - 1))) >> RESCALE_SH;
  end

  // Shared multiplier operand selection.
  always_comb begin
    unique case (state_q)
      S_XQ:    begin mul_a = 32'(job_q.an);  mul_b = 32'(INV_13);        end
      S_LOG:   begin mul_a = 32'(m_q);       mul_b = 32'(m_q);           end
      S_LG:    begin mul_a = 32'(lval);      mul_b = 32'(gamma_sat);     end
      S_DMUL:  begin mul_a = 32'(v_q);       mul_b = 32'(RECIP_100);     end
      S_EXP:   begin mul_a = 32'(r_q);       mul_b = 32'(EXP_ROM[cnt_q]); end
      S_GMUL:  begin mul_a = 32'(r_q);       mul_b = 32'(gain_sat);      end
      S_FMUL:  begin mul_a = 32'(ad);        mul_b = 32'(factor);        end
      default: begin mul_a = '0;             mul_b = '0;                 end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  logic out_free;
  assign out_free = !out_valid_o || !out_stall_i;
  assign pop_o    = (state_q == S_IDLE) && !empty_i;

  // Sequencer, datapath registers and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
      filt_q      <= '0;
      cnt_q       <= '0;
      slot_q      <= 1'b0;
      op_q        <= OP_Y;
    end else begin
      if (out_valid_o && !out_stall_i && (state_q != S_FOUT)) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            job_q  <= head_i;
            c1_q   <= '0;
            c2_q   <= '0;
            slot_q <= 1'b0;
            r_q    <= '0;
            if (head_i.kind == K_NONE) begin
              state_q <= S_FMUL;
            end else if (head_i.an == '0) begin
              state_q <= S_GMUL;
            end else begin
              state_q <= S_XQ;
            end
          end
        end
        S_XQ: begin
          prod_q  <= prod;
          state_q <= S_NORM;
        end
        S_NORM: begin
          m_q     <= m_norm;
          lz_q    <= lz;
          frac_q  <= '0;
          cnt_q   <= '0;
          state_q <= S_LOG;
        end
        // One squaring per cycle yields one bit of the log fraction.
        S_LOG: begin
          if (sq[31]) begin
            m_q    <= sq[31:1];
            frac_q <= {frac_q[14:0], 1'b1};
          end else begin
            m_q    <= sq[30:0];
            frac_q <= {frac_q[14:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 4'd15) begin
            state_q <= S_LG;
          end
        end
        S_LG: begin
          v_q     <= 27'(prod) + 27'd50;
          op_q    <= OP_Y;
          state_q <= S_DMUL;
        end
        S_DMUL: begin
          prod_q  <= prod;
          state_q <= S_DFIX;
        end
        S_DFIX: begin
          unique case (op_q)
            OP_Y: begin
              y_q     <= qv[19:0];
              r_q     <= ONE_Q30;
              cnt_q   <= '0;
              state_q <= S_EXP;
            end
            OP_GAIN: begin
              if (!slot_q) begin
                c1_q <= (qv > 21'h8000) ? 16'h8000 : qv[15:0];
                if (need2) begin
                  slot_q  <= 1'b1;
                  state_q <= S_GMUL;
                end else begin
                  state_q <= S_FMUL;
                end
              end else begin
                c2_q    <= (qv > 21'h8000) ? 16'h8000 : qv[15:0];
                state_q <= S_FMUL;
              end
            end
            default: begin
              delta_q <= qv;
              state_q <= S_FOUT;
            end
          endcase
        end
        // One fraction bit of 2^-y per cycle, from the MSB down.
        S_EXP: begin
          if (y_q[4'd15 - cnt_q]) begin
            r_q <= r_step[60:30];
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 4'd15) begin
            state_q <= S_SHR;
          end
        end
        S_SHR: begin
          r_q     <= r_q >> y_q[19:16];
          state_q <= S_GMUL;
        end
        S_GMUL: begin
          v_q     <= 27'(prod >> (30 - STRENGTH_FRAC_BITS)) + 27'd50;
          op_q    <= OP_GAIN;
          state_q <= S_DMUL;
        end
        S_FMUL: begin
          dneg_q  <= diff[STATE_W];
          v_q     <= 27'((prod + 64'd200) >> 2);
          op_q    <= OP_FILT;
          state_q <= S_DMUL;
        end
        S_FOUT: begin
          if (out_free) begin
            filt_q              <= dead ? '0 : filt_new[STATE_W-1:0];
            out_valid_o         <= 1'b1;
            spring_strength_o   <= (job_q.kind != K_SPRING) ? '0 :
                                   job_q.neg ? -$signed({1'b0, c1_q}) :
                                   $signed({1'b0, c1_q});
            friction_strength_o <= (job_q.kind == K_FRICTION) ? c1_q : '0;
            sine_strength_o     <= (job_q.kind == K_VIBE) ? c1_q : '0;
            rumble_low_o        <= (job_q.kind == K_VIBE || job_q.kind == K_ROLL_R) ?
                                   c2_q : '0;
            rumble_high_o       <= (job_q.kind == K_VIBE || job_q.kind == K_ROLL_L) ?
                                   c2_q : '0;
            force_direction_o   <= !dead && filt_new[STATE_W];
            force_magnitude_o   <= dead ? '0 : 16'(fmag);
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/ffb_command_byte_shaper.sv
// ----------------------------------------------------------------------------
// ffb_command_byte_shaper
// Force-feedback command byte decoder, response curve shaper and force filter.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the input channel (in_valid_i high, in_stall_o low) brings
// one observed byte read. Reads of the three command addresses, while enabled,
// produce one result transfer on the output channel carrying all effect
// strengths; every other read is taken and produces nothing.
// The decoder takes a read each cycle, unless the queue is full, into a
// four-entry queue. The datapath shares one multiplier; a command that drives
// a curve runs two 16-step log and exp loops plus the divide-by-100 steps,
// and the gain and divide steps once more for a second gain; an unused
// command byte runs the filter step alone.
// Configuration transfers (cfg_valid_i with cfg_ready_o) write the register
// selected by cfg_index_i; they are taken in any cycle and apply to items
// processed afterwards.
// Reset sets the registers to their defaults, clears the queue and the
// filter state. When the receiver stalls, the finished result holds in the
// output register, the datapath waits, and the queue accepts reads until full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffb_command_byte_shaper
  import ffbcs_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        read_address_i,
  input  logic               is_relative_i,
  input  logic [7:0]         cmd_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [16:0] spring_strength_o,
  output logic [15:0]        friction_strength_o,
  output logic [15:0]        sine_strength_o,
  output logic [15:0]        rumble_low_o,
  output logic [15:0]        rumble_high_o,
  output logic               force_direction_o,
  output logic [15:0]        force_magnitude_o
);

  cfg_t cfg_q;
  job_t push_job, head_job;
  logic q_push, q_full, q_pop, q_empty;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable        <= 1'b1;
      cfg_q.constant_gain <= 8'd100;
      cfg_q.spring_gain   <= 8'd45;
      cfg_q.friction_gain <= 8'd35;
      cfg_q.sine_gain     <= 8'd30;
      cfg_q.rumble_gain   <= 8'd20;
      cfg_q.gamma         <= 8'd85;
      cfg_q.smoothing     <= 8'd35;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_e'(cfg_index_i))
        REG_ENABLE:        cfg_q.enable        <= cfg_data_i[0];
        REG_CONST_GAIN:    cfg_q.constant_gain <= cfg_data_i;
        REG_SPRING_GAIN:   cfg_q.spring_gain   <= cfg_data_i;
        REG_FRICTION_GAIN: cfg_q.friction_gain <= cfg_data_i;
        REG_SINE_GAIN:     cfg_q.sine_gain     <= cfg_data_i;
        REG_RUMBLE_GAIN:   cfg_q.rumble_gain   <= cfg_data_i;
        REG_GAMMA:         cfg_q.gamma         <= cfg_data_i;
        REG_SMOOTHING:     cfg_q.smoothing     <= cfg_data_i;
      endcase
    end
  end

  // Front end: match and classify.
  ffbcs_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .read_address_i (read_address_i),
    .is_relative_i  (is_relative_i),
    .cmd_byte_i     (cmd_byte_i),
    .enable_i       (cfg_q.enable),
    .full_i         (q_full),
    .push_o         (q_push),
    .job_o          (push_job)
  );

  // Command queue.
  ffbcs_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head_job)
  );

  // Back end: shaping and filter.
  ffbcs_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .empty_i             (q_empty),
    .head_i              (head_job),
    .pop_o               (q_pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .spring_strength_o   (spring_strength_o),
    .friction_strength_o (friction_strength_o),
    .sine_strength_o     (sine_strength_o),
    .rumble_low_o        (rumble_low_o),
    .rumble_high_o       (rumble_high_o),
    .force_direction_o   (force_direction_o),
    .force_magnitude_o   (force_magnitude_o)
  );

  // The queue is never written while full.
  `FFBCS_NEVER(a_no_overflow, clk_i, rst_ni, q_push && q_full, "queue overflow")
  // A negative force (direction bit set) is always outside the deadband.
  `FFBCS_ASSERT(a_dir_mag, clk_i, rst_ni, out_valid_o && force_direction_o |-> force_magnitude_o != 16'd0, "direction without magnitude")
  // Friction and sine strengths never exceed full scale.
  `FFBCS_ASSERT(a_fric_max, clk_i, rst_ni, out_valid_o |-> friction_strength_o <= 16'h8000 && sine_strength_o <= 16'h8000, "strength above full scale")

endmodule

FILE: dv/ffb_command_byte_shaper_tb.sv
// ----------------------------------------------------------------------------
// ffb_command_byte_shaper_tb
// Self-checking testbench for the force-feedback command byte shaper.
// A driver sends observed byte reads from a queue, and a behavioral model
// predicts the effect strengths and the filtered force of every matching
// read. A monitor compares each result transfer against the oldest
// prediction. The run goes through several register settings, including
// the extremes, and applies random idle bursts and a long output hold-off.
// ----------------------------------------------------------------------------
module ffb_command_byte_shaper_tb
  import ffbcs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 400;
  localparam int HOLD_CYCLES = 500;

  typedef struct {
    logic [31:0] addr;
    logic        rel;
    logic [7:0]  cmd;
  } read_t;

  typedef struct {
    logic signed [16:0] spring;
    logic [15:0]        friction;
    logic [15:0]        sine;
    logic [15:0]        rlo;
    logic [15:0]        rhi;
    logic               dir;
    logic [15:0]        mag;
  } effects_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [7:0]         cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [31:0]        read_address_i;
  logic               is_relative_i;
  logic [7:0]         cmd_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [16:0] spring_strength_o;
  logic [15:0]        friction_strength_o;
  logic [15:0]        sine_strength_o;
  logic [15:0]        rumble_low_o;
  logic [15:0]        rumble_high_o;
  logic               force_direction_o;
  logic [15:0]        force_magnitude_o;

  ffb_command_byte_shaper dut (.*);

  // Shared state of the testbench processes.
  read_t    pending_reads[$];
  effects_t expected_effects[$];
  cfg_t     regs;
  longint   force_state;
  int       errors;
  int       cycles;
  bit       quiet;
  bit       hold_req;

  // Clock.
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Integer square root by the bitwise method.
  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Shaped strength sign(n) * min(1, |n/d|^gamma * gain), 15 fraction bits.
  function automatic longint shape(int n, int d, logic [7:0] gain_reg);
    longint unsigned an, xq, m, lg, y, r, t, q, one;
    int unsigned     frac, ip, fb, g, gain;
    int              e;
    one = 64'd1 << 30;
    an = (n < 0) ? -n : n;
    gain = (gain_reg > 200) ? 200 : gain_reg;
    g = regs.gamma;
    if (g < 25) g = 25;
    if (g > 250) g = 250;
    if (an == 0) return 0;
    xq = (an << 30) / d;
    if (xq > one) xq = one;
    if (xq == 0) return 0;
    // Normalize, then take the log fraction by repeated squaring.
    e = 0;
    while (e < 30 && (xq >> (e + 1)) != 0) e++;
    m = xq << (30 - e);
    frac = 0;
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    lg = (longint'(30 - e) << 16) - frac;
    y = (lg * g + 50) / 100;
    ip = y >> 16;
    fb = y & 16'hFFFF;
    if (ip >= 31) return 0;
    // Power of two from the square root chain of 2^(-2^-k).
    r = one;
    t = one >> 1;
    for (int k = 1; k <= 16; k++) begin
      t = root64(t << 30);
      if ((fb >> (16 - k)) & 1) r = (r * t + (one >> 1)) >> 30;
    end
    r = r >> ip;
    q = (((r * gain) << 15) + 50 * one) / (100 * one);
    if (q > (64'd1 << 15)) q = 64'd1 << 15;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Predict the result of one accepted read, if it causes one.
  function automatic bit predict_effects(read_t rd, output effects_t fx);
    bit     rally, generic;
    int     b;
    longint spring, friction, sine, rlo, rhi, target, tq, diff, delta, ad;
    longint unsigned sm;
    spring = 0; friction = 0; sine = 0; rlo = 0; rhi = 0; target = 0;
    fx = '{default: '0};
    b = rd.cmd;
    if (!regs.enable) return 0;
    rally = rd.rel && rd.addr == ADDR_RALLY;
    generic = (!rd.rel && rd.addr == ADDR_GEN_ABS) || (rd.rel && rd.addr == ADDR_GEN_REL);
    if (!rally && !generic) return 0;
    if (rally) begin
      if (b >= 8'hC0 && b <= 8'hDF) begin
        target = -shape(b - 191, 32, regs.constant_gain);
        rhi = shape(b - 191, 32, regs.rumble_gain);
      end else if (b >= 8'h80 && b <= 8'h9F) begin
        target = shape(b - 127, 32, regs.constant_gain);
        rlo = shape(b - 127, 32, regs.rumble_gain);
      end
    end else begin
      if (b >= 8'h0A && b <= 8'h17) begin
        spring = shape(b - 15, 8, regs.spring_gain);
      end else if (b >= 8'h20 && b <= 8'h27) begin
        friction = shape(b - 31, 8, regs.friction_gain);
      end else if (b >= 8'h30 && b <= 8'h3C) begin
        spring = shape(b - 47, 13, regs.spring_gain);
      end else if (b >= 8'h40 && b <= 8'h47) begin
        sine = shape(b - 63, 8, regs.sine_gain);
        rlo = shape(b - 63, 8, regs.rumble_gain);
        rhi = rlo;
      end else if (b >= 8'h50 && b <= 8'h57) begin
        target = -shape(b - 79, 8, regs.constant_gain);
        rhi = shape(b - 79, 8, regs.rumble_gain);
      end else if (b >= 8'h60 && b <= 8'h67) begin
        target = shape(b - 95, 8, regs.constant_gain);
        rlo = shape(b - 95, 8, regs.rumble_gain);
      end
    end
    // One-pole low-pass on the constant force, then the deadband.
    tq = target <<< 3;
    sm = (regs.smoothing > 100) ? 100 : regs.smoothing;
    diff = tq - force_state;
    ad = (diff < 0) ? -diff : diff;
    delta = (ad * (400 - 3 * sm) + 200) / 400;
    force_state = force_state + ((diff < 0) ? -delta : delta);
    ad = (force_state < 0) ? -force_state : force_state;
    if (ad * 1000 < (64'd2 << 18)) begin
      force_state = 0;
      ad = 0;
    end
    fx.spring = spring[16:0];
    fx.friction = friction[15:0];
    fx.sine = sine[15:0];
    fx.rlo = rlo[15:0];
    fx.rhi = rhi[15:0];
    fx.dir = force_state < 0;
    fx.mag = 16'((ad + 4) >> 3);
    return 1;
  endfunction

  // Driver: offers reads from the queue, with random idle bursts.
  int gap_left;
  always @(posedge clk_i) begin
    read_t    rd;
    effects_t fx;
    bit       nxt_valid;
    nxt_valid = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        rd = '{read_address_i, is_relative_i, cmd_byte_i};
        if (predict_effects(rd, fx)) expected_effects.push_back(fx);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0 && !quiet) begin
          gap_left--;
        end else if (pending_reads.size() > 0) begin
          rd = pending_reads.pop_front();
          read_address_i <= rd.addr;
          is_relative_i <= rd.rel;
          cmd_byte_i <= rd.cmd;
          nxt_valid = 1'b1;
          gap_left = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0;
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // Monitor: random stall bursts, a long hold on request, result checks.
  int stall_left;
  int hold_left;
  always @(posedge clk_i) begin
    effects_t fx;
    bit       nxt_stall;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_effects.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          fx = expected_effects.pop_front();
          if (spring_strength_o !== fx.spring) begin
            $error("spring_strength expected %0d got %0d", fx.spring, spring_strength_o);
            errors++;
          end
          if (friction_strength_o !== fx.friction) begin
            $error("friction_strength expected %0d got %0d", fx.friction,
                   friction_strength_o);
            errors++;
          end
          if (sine_strength_o !== fx.sine) begin
            $error("sine_strength expected %0d got %0d", fx.sine, sine_strength_o);
            errors++;
          end
          if (rumble_low_o !== fx.rlo) begin
            $error("rumble_low expected %0d got %0d", fx.rlo, rumble_low_o);
            errors++;
          end
          if (rumble_high_o !== fx.rhi) begin
            $error("rumble_high expected %0d got %0d", fx.rhi, rumble_high_o);
            errors++;
          end
          if (force_direction_o !== fx.dir) begin
            $error("force_direction expected %0d got %0d", fx.dir, force_direction_o);
            errors++;
          end
          if (force_magnitude_o !== fx.mag) begin
            $error("force_magnitude expected %0d got %0d", fx.mag, force_magnitude_o);
            errors++;
          end
        end
      end
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else if (quiet) begin
        nxt_stall = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 8);
        nxt_stall = 1'b1;
      end else begin
        nxt_stall = 1'b0;
      end
      out_stall_i <= nxt_stall;
    end
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Register write over the configuration channel.
  task automatic write_reg(reg_e idx, logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_ENABLE:        regs.enable = val[0];
      REG_CONST_GAIN:    regs.constant_gain = val;
      REG_SPRING_GAIN:   regs.spring_gain = val;
      REG_FRICTION_GAIN: regs.friction_gain = val;
      REG_SINE_GAIN:     regs.sine_gain = val;
      REG_RUMBLE_GAIN:   regs.rumble_gain = val;
      REG_GAMMA:         regs.gamma = val;
      default:           regs.smoothing = val;
    endcase
    @(posedge clk_i);
  endtask

  // Write the enable bit, then all other registers with g0 (odd index), g1 (even index) or random values.
  task automatic write_all(bit en, logic [7:0] g0, logic [7:0] g1, bit rnd);
    write_reg(REG_ENABLE, en);
    for (int i = 1; i < 8; i++)
      write_reg(reg_e'(i), rnd ? 8'($urandom) : ((i % 2) ? g0 : g1));
  endtask

  // Wait until every read was sent and every result arrived, plus latency.
  task automatic drain();
    while (pending_reads.size() > 0 || in_valid_i || expected_effects.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Random reads: mostly command hits, the rest noise near and far.
  task automatic queue_random(int count);
    read_t rd;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: rd = '{ADDR_GEN_ABS, 1'b0, 8'($urandom)};
        3, 4:    rd = '{ADDR_GEN_REL, 1'b1, 8'($urandom)};
        5, 6:    rd = '{ADDR_RALLY, 1'b1, 8'($urandom_range(8'h7C, 8'hE3))};
        7:       rd = '{ADDR_GEN_ABS, 1'b0, 8'($urandom_range(8'h50, 8'h67))};
        8:       rd = '{$urandom, 1'($urandom), 8'($urandom)};
        default: begin
          rd = '{ADDR_RALLY ^ (32'd1 << $urandom_range(0, 31)), 1'($urandom), 8'($urandom)};
        end
      endcase
      pending_reads.push_back(rd);
    end
  endtask

  // Main sequence.
  initial begin
    logic [7:0] edge_bytes[$];
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    read_address_i = '0;
    is_relative_i = 1'b0;
    cmd_byte_i = '0;
    out_stall_i = 1'b0;
    errors = 0;
    cycles = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    gap_left = 0;
    stall_left = 0;
    hold_left = 0;
    force_state = 0;
    regs = '{1'b1, 8'd100, 8'd45, 8'd35, 8'd30, 8'd20, 8'd85, 8'd35};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: range edges of each command group, both decoders, misses.
    edge_bytes = '{8'h0A, 8'h0F, 8'h17, 8'h20, 8'h27, 8'h30, 8'h3C, 8'h40, 8'h47,
                   8'h50, 8'h57, 8'h60, 8'h67, 8'h00, 8'hFF};
    foreach (edge_bytes[i]) pending_reads.push_back('{ADDR_GEN_ABS, 1'b0, edge_bytes[i]});
    pending_reads.push_back('{ADDR_GEN_REL, 1'b1, 8'h67});
    pending_reads.push_back('{ADDR_RALLY, 1'b1, 8'hC0});
    pending_reads.push_back('{ADDR_RALLY, 1'b1, 8'hDF});
    pending_reads.push_back('{ADDR_RALLY, 1'b1, 8'h80});
    pending_reads.push_back('{ADDR_RALLY, 1'b1, 8'h9F});
    pending_reads.push_back('{ADDR_RALLY, 1'b1, 8'hBF});
    pending_reads.push_back('{ADDR_RALLY, 1'b0, 8'h9F});
    pending_reads.push_back('{ADDR_GEN_ABS, 1'b1, 8'h60});
    pending_reads.push_back('{32'hFFFF_FFFF, 1'b1, 8'hFF});
    drain();

    // Default settings with a long output hold-off.
    hold_req = 1'b1;
    queue_random(200);
    drain();

    // All registers but enable at their low extreme.
    write_all(1'b1, 8'd0, 8'd0, 1'b0);
    queue_random(150);
    drain();

    // All registers at their high extreme.
    write_all(1'b1, 8'hFF, 8'hFF, 1'b0);
    queue_random(200);
    drain();

    // Disabled: nothing comes back and the filter holds.
    write_all(1'b0, 8'd100, 8'd200, 1'b0);
    queue_random(100);
    drain();

    // Random settings.
    for (int p = 0; p < 3; p++) begin
      write_all(1'b1, 8'd0, 8'd0, 1'b1);
      queue_random(180);
      drain();
    end

    // Saturation boundaries, then a final stretch without idling.
    write_all(1'b1, 8'd200, 8'd25, 1'b0);
    write_reg(REG_GAMMA, 8'd250);
    write_reg(REG_SMOOTHING, 8'd100);
    queue_random(100);
    drain();
    write_all(1'b1, 8'd1, 8'd24, 1'b1);
    quiet = 1'b1;
    queue_random(120);
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: ffb_command_byte_shaper.f
+incdir+design
design/ffbcs_pkg.sv
design/ffbcs_front.sv
design/ffbcs_queue.sv
design/ffbcs_back.sv
design/ffb_command_byte_shaper.sv
dv/ffb_command_byte_shaper_tb.sv
